// ===== design/msfd_pkg.sv =====
// shared types and constants for the motor status frame deframer
`timescale 1ns / 1ps

package msfd_pkg;

    // frame layout
    localparam logic [7:0] HEADER_BYTE     = 8'h55;
    localparam int         BYTES_PER_MOTOR = 6;
    localparam int         CFG_W           = 3;
    localparam logic [CFG_W-1:0] MOTOR_COUNT_RESET = 3'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one motor record as it leaves the front: raw frame bytes, oldest first
    typedef struct packed {
        logic [1:0]                          motor_index;
        logic                                last_motor;
        logic [BYTES_PER_MOTOR-1:0][7:0]     raw;
    } t_rec;

    // front state machine
    typedef enum logic {
        FS_RECV,
        FS_EMIT
    } t_fstate;

endpackage

// ===== design/msfd_front.sv =====
// front: byte window, running sums, frame check and record generation
`timescale 1ns / 1ps

module msfd_front #(
    parameter int MAX_MOTORS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_cfg_valid,
    input  logic [msfd_pkg::CFG_W-1:0] i_cfg_data,
    output logic                 o_push,
    output msfd_pkg::t_rec       o_rec,
    input  logic                 i_q_full
);
    import msfd_pkg::*;

    localparam int WIN_DEPTH = MAX_MOTORS * BYTES_PER_MOTOR + 2;
    localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);
    localparam int CNT_W     = $clog2(MAX_MOTORS + 1);

    logic [7:0]        r_win [WIN_DEPTH];
    logic [7:0]        r_sum [MAX_MOTORS];
    logic [SEEN_W-1:0] r_seen;
    logic [CFG_W-1:0]  r_mcount;
    logic [CNT_W-1:0]  r_mot;
    t_fstate           r_state;
    t_fstate           n_state;

    logic [CNT_W-1:0]  motors;
    logic [SEEN_W-1:0] active_len;
    logic [SEEN_W-1:0] seen_nx;
    logic [7:0]        hdr_byte;
    logic [7:0]        chk_sum;
    logic              accept;
    logic              match;
    logic              last_rec;
    logic [CNT_W-1:0]  grp;

    // clamp the motor count into range
    always_comb begin
        if (r_mcount == '0) begin
            motors = CNT_W'(1);
        end else if (int'(r_mcount) > MAX_MOTORS) begin
            motors = CNT_W'(MAX_MOTORS);
        end else begin
            motors = CNT_W'(r_mcount);
        end
    end

    assign active_len = SEEN_W'(int'(motors) * BYTES_PER_MOTOR + 2);
    assign seen_nx    = (int'(r_seen) == WIN_DEPTH) ? r_seen : r_seen + SEEN_W'(1);
    assign accept     = i_rx_valid && o_rx_ready;

    // header tap and sum for the active frame length
    always_comb begin
        hdr_byte = '0;
        chk_sum  = '0;
        for (int k = 0; k < MAX_MOTORS; k++) begin
            if (motors == CNT_W'(k + 1)) begin
                hdr_byte = r_win[(k + 1) * BYTES_PER_MOTOR];
                chk_sum  = r_sum[k];
            end
        end
    end

    assign match = (seen_nx >= active_len) && (hdr_byte == HEADER_BYTE)
                   && (chk_sum == i_rx_byte);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_RECV: begin
                if (accept && match) n_state = FS_EMIT;
            end
            FS_EMIT: begin
                if (o_push && last_rec) n_state = FS_RECV;
            end
            default: n_state = FS_RECV;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_rx_ready = 1'b0;
        o_push     = 1'b0;
        unique case (r_state)
            FS_RECV: o_rx_ready = 1'b1;
            FS_EMIT: o_push     = !i_q_full;
            default: o_rx_ready = 1'b0;
        endcase
    end

    // record of the current motor, groups counted back from the header
    assign last_rec = (r_mot == motors - CNT_W'(1));
    assign grp      = motors - r_mot;

    always_comb begin
        o_rec.motor_index = 2'(r_mot);
        o_rec.last_motor  = last_rec;
        o_rec.raw         = '0;
        for (int k = 0; k < MAX_MOTORS; k++) begin
            if (grp == CNT_W'(k + 1)) begin
                for (int b = 0; b < BYTES_PER_MOTOR; b++) begin
                    o_rec.raw[BYTES_PER_MOTOR-1-b] = r_win[(k + 1) * BYTES_PER_MOTOR - b];
                end
            end
        end
    end

    // window shift and running sums for every frame length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_DEPTH; k++) r_win[k] <= '0;
            for (int k = 0; k < MAX_MOTORS; k++) r_sum[k] <= '0;
            r_seen <= '0;
        end else if (accept) begin
            r_win[0] <= i_rx_byte;
            for (int k = 1; k < WIN_DEPTH; k++) r_win[k] <= r_win[k-1];
            for (int k = 0; k < MAX_MOTORS; k++) begin
                r_sum[k] <= r_sum[k] + i_rx_byte - r_win[(k + 1) * BYTES_PER_MOTOR];
            end
            r_seen <= seen_nx;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcount <= MOTOR_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_mcount <= i_cfg_data;
        end
    end

    // state and motor counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_RECV;
            r_mot   <= '0;
        end else begin
            r_state <= n_state;
            if (o_push) begin
                r_mot <= last_rec ? '0 : r_mot + CNT_W'(1);
            end
        end
    end

endmodule

// ===== design/msfd_queue.sv =====
// short record queue between front and back
`timescale 1ns / 1ps

module msfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msfd_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output msfd_pkg::t_rec o_rec,
    output logic           o_empty
);
    import msfd_pkg::*;

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (int'(r_cnt) == QUEUE_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_rec;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + QPTR_W'(1);
            if (do_pop)  r_rd <= r_rd + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/msfd_back.sv =====
// back: unpacks records into fields and holds them in the output register
`timescale 1ns / 1ps

module msfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msfd_pkg::t_rec     i_rec,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_rec_valid,
    input  logic               i_rec_ready,
    output logic [1:0]         o_motor_index,
    output logic [14:0]        o_angle,
    output logic signed [15:0] o_speed,
    output logic signed [15:0] o_current,
    output logic               o_last_motor
);
    import msfd_pkg::*;

    logic               r_valid;
    logic [1:0]         r_index;
    logic [14:0]        r_angle;
    logic signed [15:0] r_speed;
    logic signed [15:0] r_current;
    logic               r_last;

    // load when the register is empty or being drained
    assign o_pop = !i_q_empty && (!r_valid || i_rec_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_rec_ready) begin
            r_valid <= 1'b0;
        end
    end

    // field unpacking, big endian byte pairs, angle top bit dropped
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_index   <= i_rec.motor_index;
            r_last    <= i_rec.last_motor;
            r_angle   <= {i_rec.raw[5][6:0], i_rec.raw[4]};
            r_speed   <= signed'({i_rec.raw[3], i_rec.raw[2]});
            r_current <= signed'({i_rec.raw[1], i_rec.raw[0]});
        end
    end

    assign o_rec_valid   = r_valid;
    assign o_motor_index = r_index;
    assign o_angle       = r_angle;
    assign o_speed       = r_speed;
    assign o_current     = r_current;
    assign o_last_motor  = r_last;

endmodule

// ===== design/motor_status_frame_deframer_top.sv =====
// Motor status frame deframer: serial bytes in, per-motor status records out.
// Byte channel i_rx_valid/o_rx_ready/i_rx_byte takes one received byte per
// transaction into a sliding window; running sums are kept for every frame
// length so the header and checksum test is combinational on each byte.
// A byte that completes a frame (header 0x55, mod-256 sum check) starts an
// emit phase that pushes one record per motor into a four-entry queue and
// waits while it is full; the byte channel is held off during that phase.
// The single record builder emits the records of a frame one after another
// and takes no new byte until the last record of the frame is pushed.
// A record passes the front state register, the queue and the output register.
// Record channel o_rec_valid/i_rec_ready: output register fed from the queue;
// a stalled receiver fills the queue, then stalls the emit phase, then the
// byte channel. Records of a frame come in motor order, last one flagged.
// Config channel i_cfg_valid/i_cfg_data sets motor_count (always ready);
// write it only while idle. Reset clears window, sums, count and queue, and
// loads motor_count with 2.
`timescale 1ns / 1ps

module motor_status_frame_deframer_top #(
    parameter int MAX_MOTORS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [msfd_pkg::CFG_W-1:0] i_cfg_data,
    output logic               o_rec_valid,
    input  logic               i_rec_ready,
    output logic [1:0]         o_motor_index,
    output logic [14:0]        o_angle,
    output logic signed [15:0] o_speed,
    output logic signed [15:0] o_current,
    output logic               o_last_motor
);
    import msfd_pkg::*;

    logic push;
    logic q_full;
    logic pop;
    logic q_empty;
    t_rec front_rec;
    t_rec queue_rec;

    assign o_cfg_ready = 1'b1;

    // accept and check bytes, build records
    msfd_front #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_rec       (front_rec),
        .i_q_full    (q_full)
    );

    // record queue
    msfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_rec   (queue_rec),
        .o_empty (q_empty)
    );

    // unpack and present records
    msfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (queue_rec),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .o_rec_valid   (o_rec_valid),
        .i_rec_ready   (i_rec_ready),
        .o_motor_index (o_motor_index),
        .o_angle       (o_angle),
        .o_speed       (o_speed),
        .o_current     (o_current),
        .o_last_motor  (o_last_motor)
    );

endmodule
